[sv/bcfe_pkg.sv]
// Shared types, constants and the 5b/8b code table for the bitstream
// command frame encoder. No dependencies.
`default_nettype none

package bcfe_pkg;

  // Stream geometry
  localparam int unsigned GROUP_BITS      = 10;
  localparam int unsigned LEN_W           = 12;
  localparam logic [LEN_W-1:0] MAX_STREAM_BITS = 12'd4095;

  // Reciprocal of GROUP_BITS in 16-bit fraction, exact for values below 4096
  localparam logic [12:0] DIV10_MUL = 13'd6554;

  // Clear frame constants
  localparam logic [7:0] CLEAR_SYNCS  = 8'd60;
  localparam logic [4:0] BROADCAST_ID = 5'd16;

  // Frame slots of one input item, sent lowest first
  localparam int unsigned NUM_SLOTS = 9;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_CLEAR    = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_MAN0     = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_MAN_CK1  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_MAN2     = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_MAN_CK2  = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_MAN4     = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_BLOCK    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_LOAD     = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_LOAD_END = 4'd8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE            = 3'd0,
    CFG_CHIP_ID         = 3'd1,
    CFG_LOAD_PATTERN    = 3'd2,
    CFG_SYNC_SPACING    = 3'd3,
    CFG_STREAM_LENGTH   = 3'd4,
    CFG_REGWRITE_HEADER = 3'd5,
    CFG_SETBIT_HEADER   = 3'd6,
    CFG_SYNC_WORD       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             mode;
    logic [4:0]       chip_id;
    logic [9:0]       load_pattern;
    logic [5:0]       sync_spacing;
    logic [LEN_W-1:0] stream_length;
    logic [15:0]      regwrite_header;
    logic [15:0]      setbit_header;
  } cfg_t;

  // What one accepted item leaves for the frame builder
  typedef struct packed {
    logic       mode;
    logic       bit_value;
    logic [9:0] word;
  } job_t;

  typedef struct packed {
    logic [7:0] sync_repeat;
    logic [7:0] data_high_code;
    logic [7:0] data_low_code;
    logic [7:0] chip_code;
    logic [7:0] address_code;
    logic [7:0] header_high;
    logic [7:0] header_low;
  } frame_t;

  // Balanced 5b/8b code
  function automatic logic [7:0] code5b8b(input logic [4:0] v);
    logic [7:0] c;
    case (v)
      5'd0:  c = 8'h6A;  5'd1:  c = 8'h6C;  5'd2:  c = 8'h71;  5'd3:  c = 8'h72;
      5'd4:  c = 8'h74;  5'd5:  c = 8'h8B;  5'd6:  c = 8'h8D;  5'd7:  c = 8'h8E;
      5'd8:  c = 8'h93;  5'd9:  c = 8'h95;  5'd10: c = 8'h96;  5'd11: c = 8'h99;
      5'd12: c = 8'h9A;  5'd13: c = 8'h9C;  5'd14: c = 8'hA3;  5'd15: c = 8'hA5;
      5'd16: c = 8'hA6;  5'd17: c = 8'hA9;  5'd18: c = 8'hAA;  5'd19: c = 8'hAC;
      5'd20: c = 8'hB1;  5'd21: c = 8'hB2;  5'd22: c = 8'hB4;  5'd23: c = 8'hC3;
      5'd24: c = 8'hC5;  5'd25: c = 8'hC6;  5'd26: c = 8'hC9;  5'd27: c = 8'hCA;
      5'd28: c = 8'hCC;  5'd29: c = 8'hD1;  5'd30: c = 8'hD2;  5'd31: c = 8'hD4;
      default: c = 8'h6A;
    endcase
    return c;
  endfunction

  // Lowest pending slot of a slot mask
  function automatic logic [SLOT_W-1:0] first_slot(input logic [NUM_SLOTS-1:0] m);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) s = SLOT_W'(i);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/bcfe_frame.sv]
// Frame builder: turns a slot number, the pending item and the live
// configuration into one six-byte command frame. Uses bcfe_pkg.
`default_nettype none

module bcfe_frame (
  input  wire logic [bcfe_pkg::SLOT_W-1:0] slot_i,
  input  wire bcfe_pkg::job_t              job_i,
  input  wire bcfe_pkg::cfg_t              cfg_i,
  output bcfe_pkg::frame_t                 frame_o
);

  logic [15:0] header;
  logic [4:0]  chip;
  logic [9:0]  data;
  logic [7:0]  syncs;

  // Per-slot header, chip, data and sync count
  always_comb begin
    header = cfg_i.setbit_header;
    chip   = cfg_i.chip_id;
    data   = '0;
    syncs  = {2'b00, cfg_i.sync_spacing};
    case (slot_i)
      bcfe_pkg::SLOT_CLEAR: begin
        header = cfg_i.regwrite_header;
        chip   = bcfe_pkg::BROADCAST_ID;
        syncs  = bcfe_pkg::CLEAR_SYNCS;
      end
      bcfe_pkg::SLOT_MAN0, bcfe_pkg::SLOT_MAN2, bcfe_pkg::SLOT_MAN4: begin
        data = {9'd0, job_i.bit_value};
      end
      bcfe_pkg::SLOT_MAN_CK1: begin
        data = {8'd0, 1'b1, job_i.bit_value};
      end
      bcfe_pkg::SLOT_MAN_CK2: begin
        data = {7'd0, 2'b10, job_i.bit_value};
      end
      bcfe_pkg::SLOT_BLOCK: begin
        header = cfg_i.regwrite_header;
        data   = job_i.word;
      end
      bcfe_pkg::SLOT_LOAD: begin
        data  = cfg_i.load_pattern;
        syncs = job_i.mode ? {cfg_i.sync_spacing, 2'b00} : 8'd1;
      end
      bcfe_pkg::SLOT_LOAD_END: begin
        syncs = '0;
      end
      default: begin
        syncs = '0;
      end
    endcase
  end

  // Byte encoding
  always_comb begin
    frame_o.header_low     = header[7:0];
    frame_o.header_high    = header[15:8];
    frame_o.address_code   = bcfe_pkg::code5b8b(5'd0);
    frame_o.chip_code      = bcfe_pkg::code5b8b(chip);
    frame_o.data_low_code  = bcfe_pkg::code5b8b(data[4:0]);
    frame_o.data_high_code = bcfe_pkg::code5b8b(data[9:5]);
    frame_o.sync_repeat    = syncs;
  end

endmodule

`default_nettype wire

[sv/bitstream_command_frame_encoder.sv]
// Top level of the bitstream command frame encoder: stream state, frame
// slot sequencing and the output register. Uses bcfe_pkg and bcfe_frame.
`default_nettype none

// Takes one configuration bit per input transfer and sends six-byte command
// frames, one per output transfer, each tagged with its sync count; tlast marks
// the last frame caused by an input bit. In block mode (mode 0) every tenth bit
// (counted so the stream is left-padded to whole groups) adds one frame. In
// manual mode each bit sends five frames, six on the first bit of a stream. The
// end of the stream adds two load frames when load_pattern is nonzero. The
// single output frame register sends one frame per cycle while the output is
// not stalled; a new bit is taken in the cycle its predecessor's last frame
// moves into that register. Configuration writes are always taken and must be
// made while idle.
module bitstream_command_frame_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] bit_value, [7:1] zero
  // Output frames
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // header_low, header_high, address_code,
                                           // chip_code, data_low_code,
                                           // data_high_code, sync_repeat
  output logic             m_axis_tlast    // last_frame
);

  localparam int unsigned NS = bcfe_pkg::NUM_SLOTS;
  localparam int unsigned LW = bcfe_pkg::LEN_W;

  bcfe_pkg::cfg_t   cfg_q;
  bcfe_pkg::job_t   job_q, job_d;
  bcfe_pkg::frame_t frame, out_q;

  logic [9:0]    acc_q, acc_d;
  logic [LW-1:0] sbc_q, sbc_d;
  logic [NS-1:0] mask_q, mask_d, mask_new, mask_clr;
  logic          out_valid_q, out_valid_d, out_last_q;

  logic          accept, emit;
  logic [bcfe_pkg::SLOT_W-1:0] slot;
  logic [LW-1:0] len_eff, count, diff;
  logic [24:0]   prod;
  logic [LW-1:0] quot;
  logic [LW-1:0] rem;
  logic          at_end, boundary, bit_in;
  logic [9:0]    word_next;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 1'b0, chip_id: 5'd0, load_pattern: 10'd0, sync_spacing: 6'd0,
                 stream_length: LW'(1), regwrite_header: 16'd0, setbit_header: 16'd0};
    end else if (cfg_valid_i) begin
      case (bcfe_pkg::cfg_idx_e'(cfg_index_i))
        bcfe_pkg::CFG_MODE:            cfg_q.mode            <= cfg_data_i[0];
        bcfe_pkg::CFG_CHIP_ID:         cfg_q.chip_id         <= cfg_data_i[4:0];
        bcfe_pkg::CFG_LOAD_PATTERN:    cfg_q.load_pattern    <= cfg_data_i[9:0];
        bcfe_pkg::CFG_SYNC_SPACING:    cfg_q.sync_spacing    <= cfg_data_i[5:0];
        bcfe_pkg::CFG_STREAM_LENGTH:   cfg_q.stream_length   <= cfg_data_i[LW-1:0];
        bcfe_pkg::CFG_REGWRITE_HEADER: cfg_q.regwrite_header <= cfg_data_i;
        bcfe_pkg::CFG_SETBIT_HEADER:   cfg_q.setbit_header   <= cfg_data_i;
        // sync word is carried by count only and never enters a frame
        default: ;
      endcase
    end
  end

  // Stream position and group boundary of the incoming bit
  always_comb begin
    bit_in    = s_axis_tdata[0];
    len_eff   = (cfg_q.stream_length == '0) ? LW'(1) : cfg_q.stream_length;
    if (len_eff > bcfe_pkg::MAX_STREAM_BITS) len_eff = bcfe_pkg::MAX_STREAM_BITS;
    count     = sbc_q + LW'(1);
    at_end    = count >= len_eff;
    diff      = len_eff - count;
    // diff mod 10 through the reciprocal
    prod      = 25'(diff) * 25'(bcfe_pkg::DIV10_MUL);
    quot      = LW'(prod[24:16]);
    rem       = diff - LW'(quot * LW'(bcfe_pkg::GROUP_BITS));
    boundary  = at_end || (rem == '0);
    word_next = {acc_q[8:0], bit_in};
  end

  // Frames this bit will cause
  always_comb begin
    mask_new = '0;
    mask_new[bcfe_pkg::SLOT_CLEAR]    = cfg_q.mode && (sbc_q == '0);
    mask_new[bcfe_pkg::SLOT_MAN0]     = cfg_q.mode;
    mask_new[bcfe_pkg::SLOT_MAN_CK1]  = cfg_q.mode;
    mask_new[bcfe_pkg::SLOT_MAN2]     = cfg_q.mode;
    mask_new[bcfe_pkg::SLOT_MAN_CK2]  = cfg_q.mode;
    mask_new[bcfe_pkg::SLOT_MAN4]     = cfg_q.mode;
    mask_new[bcfe_pkg::SLOT_BLOCK]    = !cfg_q.mode && boundary;
    mask_new[bcfe_pkg::SLOT_LOAD]     = at_end && (cfg_q.load_pattern != '0);
    mask_new[bcfe_pkg::SLOT_LOAD_END] = at_end && (cfg_q.load_pattern != '0);
  end

  // Slot sequencing and handshakes
  always_comb begin
    slot     = bcfe_pkg::first_slot(mask_q);
    mask_clr = mask_q & ~(NS'(1) << slot);
    emit     = (mask_q != '0) && (!out_valid_q || m_axis_tready);
    s_axis_tready = (mask_q == '0) || (emit && (mask_clr == '0));
    accept   = s_axis_tvalid && s_axis_tready;

    mask_d = mask_q;
    if (emit) mask_d = mask_clr;
    if (accept) mask_d = mask_new;

    job_d = job_q;
    acc_d = acc_q;
    sbc_d = sbc_q;
    if (accept) begin
      job_d.mode      = cfg_q.mode;
      job_d.bit_value = bit_in;
      job_d.word      = word_next;
      acc_d = boundary ? '0 : word_next;
      sbc_d = at_end ? '0 : count;
    end

    out_valid_d = out_valid_q;
    if (emit) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  bcfe_frame u_frame (
    .slot_i  (slot),
    .job_i   (job_q),
    .cfg_i   (cfg_q),
    .frame_o (frame)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      acc_q       <= '0;
      sbc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      acc_q       <= acc_d;
      sbc_q       <= sbc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      out_q      <= frame;
      out_last_q <= (mask_clr == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

[verif/tb_bitstream_command_frame_encoder.sv]
// Testbench for bitstream_command_frame_encoder: drives stream bits and register
// writes, predicts every command frame and checks the output stream in order.
// Depends on bcfe_pkg and the encoder RTL.
module tb_bitstream_command_frame_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_BITS  = 355;
  localparam int unsigned MAX_REPORTS  = 50;
  localparam logic MODE_BLOCK  = 1'b0;
  localparam logic MODE_MANUAL = 1'b1;
  localparam logic [7:0] LOAD_SYNCS_BLOCK = 8'd1;

  // Balanced 5b/8b code, indexed by the 5-bit value
  localparam logic [7:0] BAL_CODE [0:31] = '{
    8'h6A, 8'h6C, 8'h71, 8'h72, 8'h74, 8'h8B, 8'h8D, 8'h8E,
    8'h93, 8'h95, 8'h96, 8'h99, 8'h9A, 8'h9C, 8'hA3, 8'hA5,
    8'hA6, 8'hA9, 8'hAA, 8'hAC, 8'hB1, 8'hB2, 8'hB4, 8'hC3,
    8'hC5, 8'hC6, 8'hC9, 8'hCA, 8'hCC, 8'hD1, 8'hD2, 8'hD4
  };

  typedef struct packed {
    logic             last;
    bcfe_pkg::frame_t f;
  } exp_frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Predictor copy of the registers and the stream state
  logic        cfg_mode = MODE_BLOCK;
  logic [4:0]  cfg_chip = '0;
  logic [9:0]  cfg_load = '0;
  logic [5:0]  cfg_spacing = '0;
  logic [11:0] cfg_len = 12'd1;
  logic [15:0] cfg_rw_hdr = '0;
  logic [15:0] cfg_sb_hdr = '0;
  logic [15:0] cfg_sync_word = '0;
  logic [9:0]  acc_word = '0;
  logic [3:0]  group_cnt = '0;
  logic [11:0] bit_pos = '0;

  exp_frame_t  expected_frames [$];
  int unsigned mismatches = 0;
  int unsigned frames_seen = 0;
  int unsigned bits_sent = 0;
  int unsigned cycle_count = 0;
  int          hold_left = 0;
  logic        gaps_on = 1'b0;
  logic        stalls_on = 1'b0;

  bitstream_command_frame_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle length: mostly none, often short, sometimes long
  function automatic int pick_gap(logic enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random bits above a register field, so the field mask is exercised
  function automatic logic [15:0] with_junk(int unsigned v, int w);
    return 16'(($urandom << w) | v);
  endfunction

  function automatic void push_frame(logic [15:0] hdr, logic [4:0] chip, logic [9:0] data,
                                     logic [7:0] syncs);
    exp_frame_t e;
    e.last             = 1'b0;
    e.f.header_low     = hdr[7:0];
    e.f.header_high    = hdr[15:8];
    e.f.address_code   = BAL_CODE[0];
    e.f.chip_code      = BAL_CODE[chip];
    e.f.data_low_code  = BAL_CODE[data[4:0]];
    e.f.data_high_code = BAL_CODE[data[9:5]];
    e.f.sync_repeat    = syncs;
    expected_frames.insert(expected_frames.size(), e);
  endfunction

  // Frames caused by one stream bit; updates the stream state
  function automatic void encode_bit(logic b);
    int unsigned len, cnt;
    int          depth;
    logic        at_end, boundary;
    logic [7:0]  syncs;
    depth = expected_frames.size();
    len   = (cfg_len == 0) ? 1 : cfg_len;
    syncs = {2'b00, cfg_spacing};

    // Clear frame opens a stream that starts in manual mode
    if (cfg_mode == MODE_MANUAL && bit_pos == 0)
      push_frame(cfg_rw_hdr, bcfe_pkg::BROADCAST_ID, 10'd0, bcfe_pkg::CLEAR_SYNCS);

    acc_word  = {acc_word[8:0], b};
    group_cnt = group_cnt + 4'd1;
    cnt       = bit_pos + 1;
    at_end    = (cnt >= len);
    boundary  = at_end || (((len - cnt) % bcfe_pkg::GROUP_BITS) == 0);

    if (cfg_mode == MODE_BLOCK) begin
      if (boundary) push_frame(cfg_rw_hdr, cfg_chip, acc_word, syncs);
    end else begin
      // data, clock 1, data, clock 2, data
      push_frame(cfg_sb_hdr, cfg_chip, 10'(b), syncs);
      push_frame(cfg_sb_hdr, cfg_chip, 10'(b) + 10'd2, syncs);
      push_frame(cfg_sb_hdr, cfg_chip, 10'(b), syncs);
      push_frame(cfg_sb_hdr, cfg_chip, 10'(b) + 10'd4, syncs);
      push_frame(cfg_sb_hdr, cfg_chip, 10'(b), syncs);
    end

    if (boundary) begin
      group_cnt = '0;
      acc_word  = '0;
    end

    if (at_end) begin
      // Load pulse, then release
      if (cfg_load != 0) begin
        push_frame(cfg_sb_hdr, cfg_chip, cfg_load,
                   (cfg_mode == MODE_BLOCK) ? LOAD_SYNCS_BLOCK : {cfg_spacing, 2'b00});
        push_frame(cfg_sb_hdr, cfg_chip, 10'd0, 8'd0);
      end
      bit_pos   = '0;
      acc_word  = '0;
      group_cnt = '0;
    end else begin
      bit_pos = cnt[11:0];
    end

    if (expected_frames.size() > depth)
      expected_frames[expected_frames.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_REPORTS)
      $display("frame %0d: %s got 0x%0h expected 0x%0h", frames_seen, what, got, want);
    mismatches++;
  endtask

  // Output stall pattern, changed at the falling edge
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else begin
      hold_left = pick_gap(stalls_on);
      m_axis_tready <= (hold_left == 0);
    end
  end

  // Output checker: each frame transfer against the oldest expectation
  always @(posedge clk_i) begin
    bcfe_pkg::frame_t got;
    exp_frame_t       want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_frames.size() == 0) begin
        report_mismatch("frame with nothing expected, header_low", got.header_low, 0);
      end else begin
        want = expected_frames.pop_front();
        if (got.header_low !== want.f.header_low)
          report_mismatch("header_low", got.header_low, want.f.header_low);
        if (got.header_high !== want.f.header_high)
          report_mismatch("header_high", got.header_high, want.f.header_high);
        if (got.address_code !== want.f.address_code)
          report_mismatch("address_code", got.address_code, want.f.address_code);
        if (got.chip_code !== want.f.chip_code)
          report_mismatch("chip_code", got.chip_code, want.f.chip_code);
        if (got.data_low_code !== want.f.data_low_code)
          report_mismatch("data_low_code", got.data_low_code, want.f.data_low_code);
        if (got.data_high_code !== want.f.data_high_code)
          report_mismatch("data_high_code", got.data_high_code, want.f.data_high_code);
        if (got.sync_repeat !== want.f.sync_repeat)
          report_mismatch("sync_repeat", got.sync_repeat, want.f.sync_repeat);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_frame", m_axis_tlast, want.last);
      end
      frames_seen++;
    end
  end

  // Wait until every expected frame has arrived and the block has settled
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(bcfe_pkg::cfg_idx_e idx, logic [15:0] data);
    quiesce();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bcfe_pkg::CFG_MODE:            cfg_mode      = data[0];
      bcfe_pkg::CFG_CHIP_ID:         cfg_chip      = data[4:0];
      bcfe_pkg::CFG_LOAD_PATTERN:    cfg_load      = data[9:0];
      bcfe_pkg::CFG_SYNC_SPACING:    cfg_spacing   = data[5:0];
      bcfe_pkg::CFG_STREAM_LENGTH:   cfg_len       = data[11:0];
      bcfe_pkg::CFG_REGWRITE_HEADER: cfg_rw_hdr    = data;
      bcfe_pkg::CFG_SETBIT_HEADER:   cfg_sb_hdr    = data;
      bcfe_pkg::CFG_SYNC_WORD:       cfg_sync_word = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One bit transfer; valid stays high when the next bit follows without a gap
  task automatic send_bit(logic b);
    int gap;
    gap = pick_gap(gaps_on);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, b};
    do @(posedge clk_i); while (!s_axis_tready);
    encode_bit(b);
    bits_sent++;
  endtask

  // Defaults after reset: one-bit block streams, no load pulse
  task automatic test_reset_values();
    send_bit(1'b1);
    send_bit(1'b0);
  endtask

  // Block mode, padded group then a full group of ones, chip id above broadcast
  task automatic test_block_groups();
    write_reg(bcfe_pkg::CFG_MODE, 16'(MODE_BLOCK));
    write_reg(bcfe_pkg::CFG_CHIP_ID, 16'd31);
    write_reg(bcfe_pkg::CFG_LOAD_PATTERN, 16'd1023);
    write_reg(bcfe_pkg::CFG_SYNC_SPACING, 16'd63);
    write_reg(bcfe_pkg::CFG_STREAM_LENGTH, 16'd11);
    write_reg(bcfe_pkg::CFG_REGWRITE_HEADER, 16'hFFFF);
    write_reg(bcfe_pkg::CFG_SETBIT_HEADER, 16'h0000);
    write_reg(bcfe_pkg::CFG_SYNC_WORD, 16'hFFFF);
    repeat (11) send_bit(1'b1);
  endtask

  // Manual clocking with zero length (one bit) and the widest load sync count
  task automatic test_manual_clock();
    write_reg(bcfe_pkg::CFG_MODE, 16'(MODE_MANUAL));
    write_reg(bcfe_pkg::CFG_CHIP_ID, 16'(bcfe_pkg::BROADCAST_ID));
    write_reg(bcfe_pkg::CFG_LOAD_PATTERN, 16'h0155);
    write_reg(bcfe_pkg::CFG_STREAM_LENGTH, 16'd0);
    write_reg(bcfe_pkg::CFG_REGWRITE_HEADER, 16'h1234);
    write_reg(bcfe_pkg::CFG_SETBIT_HEADER, 16'hFFFF);
    write_reg(bcfe_pkg::CFG_SYNC_WORD, 16'h0000);
    send_bit(1'b1);
    send_bit(1'b0);
  endtask

  // Length and mode changed in the middle of a stream
  task automatic test_midstream_changes();
    write_reg(bcfe_pkg::CFG_LOAD_PATTERN, 16'd0);
    write_reg(bcfe_pkg::CFG_SYNC_SPACING, 16'd0);
    write_reg(bcfe_pkg::CFG_CHIP_ID, 16'd0);
    write_reg(bcfe_pkg::CFG_MODE, 16'(MODE_BLOCK));
    write_reg(bcfe_pkg::CFG_STREAM_LENGTH, 16'd20);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    // shrink below the count: next bit ends the stream with a partial group
    write_reg(bcfe_pkg::CFG_STREAM_LENGTH, 16'd2);
    send_bit(1'b1);
    write_reg(bcfe_pkg::CFG_MODE, 16'(MODE_MANUAL));
    write_reg(bcfe_pkg::CFG_STREAM_LENGTH, 16'd5);
    send_bit(1'b0);
    send_bit(1'b1);
    write_reg(bcfe_pkg::CFG_MODE, 16'(MODE_BLOCK));
    send_bit(1'b1);
    send_bit(1'b0);
    // back to manual mid-stream: no clear frame
    write_reg(bcfe_pkg::CFG_MODE, 16'(MODE_MANUAL));
    send_bit(1'b1);
  endtask

  // Random settings, mostly complete streams, some cut short or very long
  task automatic test_random_streams();
    int unsigned target, len, len_eff, n, r;
    target = bits_sent + RANDOM_BITS;
    while (bits_sent < target) begin
      gaps_on   = ($urandom_range(0, 99) < 80);
      stalls_on = ($urandom_range(0, 99) < 75);

      write_reg(bcfe_pkg::CFG_MODE, with_junk($urandom_range(0, 1), 1));
      r = $urandom_range(0, 99);
      if (r < 6) len = 4095;
      else if (r < 10) len = 0;
      else if (r < 80) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 40);
      write_reg(bcfe_pkg::CFG_STREAM_LENGTH, with_junk(len, 12));

      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 99);
        write_reg(bcfe_pkg::CFG_CHIP_ID,
                  with_junk((r < 15) ? 0 : (r < 30) ? 16 : (r < 45) ? 31 :
                            $urandom_range(0, 31), 5));
      end
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 99);
        write_reg(bcfe_pkg::CFG_LOAD_PATTERN,
                  with_junk((r < 45) ? 0 : (r < 55) ? 1023 :
                            (r < 60) ? 1 : $urandom_range(0, 1023), 10));
      end
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 99);
        write_reg(bcfe_pkg::CFG_SYNC_SPACING,
                  with_junk((r < 20) ? 0 : (r < 40) ? 63 : $urandom_range(0, 63), 6));
      end
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 99);
        write_reg(bcfe_pkg::CFG_REGWRITE_HEADER, (r < 15) ? 16'h0000 :
                  (r < 30) ? 16'hFFFF : 16'($urandom));
      end
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 99);
        write_reg(bcfe_pkg::CFG_SETBIT_HEADER, (r < 15) ? 16'h0000 :
                  (r < 30) ? 16'hFFFF : 16'($urandom));
      end
      if ($urandom_range(0, 99) < 30)
        write_reg(bcfe_pkg::CFG_SYNC_WORD, 16'($urandom));

      // Bits of this phase
      len_eff = (cfg_len == 0) ? 1 : cfg_len;
      if (cfg_len == 12'd4095) n = $urandom_range(3, 12);
      else if ($urandom_range(0, 99) < 80) n = (len_eff > bit_pos) ? len_eff - bit_pos : 1;
      else n = $urandom_range(1, len_eff);
      repeat (n) send_bit(1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_block_groups();
    test_manual_clock();
    test_midstream_changes();
    test_random_streams();

    quiesce();
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/bcfe_pkg.sv
sv/bcfe_frame.sv
sv/bitstream_command_frame_encoder.sv
verif/tb_bitstream_command_frame_encoder.sv
